### hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    // pool geometry
    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = IDX_W + 1;

    // chunk size limits (log2 of bytes)
    localparam logic [3:0] LG_MIN = 4'd2;
    localparam logic [3:0] LG_MAX = 4'd12;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int RIDX_W  = 2;
    localparam logic [RIDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [RIDX_W-1:0] REG_CHUNKS = 2'd1;
    localparam logic [RIDX_W-1:0] REG_LG     = 2'd2;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_SIZE  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_IDLE  = 3'd4;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;  // latch request, launch stack read
        logic commit;   // update pool state, load result register
    } fbpa_cmd_t;

    // decoded config write
    typedef struct packed {
        logic              we;
        logic [RIDX_W-1:0] idx;
        logic [31:0]       wdata;
    } fbpa_cfg_t;

endpackage

### hw/rtl/fbpa_ctrl.sv
module fbpa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output fbpa_pkg::fbpa_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result slot free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/fbpa_dp.sv
module fbpa_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  fbpa_pkg::fbpa_cfg_t cfg,
    output logic [31:0]         cfg_rdata,
    input  fbpa_pkg::fbpa_cmd_t cmd,
    input  logic                req_type,
    input  logic [12:0]         request_size,
    input  logic [31:0]         release_addr,
    output logic [2:0]          status,
    output logic [31:0]         chunk_addr,
    output logic [8:0]          used_chunks,
    output logic [20:0]         used_bytes
);

    localparam logic [fbpa_pkg::CNT_W-1:0] DEPTH_CNT = fbpa_pkg::CNT_W'(fbpa_pkg::POOL_DEPTH);

    function automatic logic [fbpa_pkg::CNT_W-1:0] clamp_chunks(input logic [8:0] n);
        if (n == 9'd0)
            return fbpa_pkg::CNT_W'(1);
        else if (fbpa_pkg::CNT_W'(n) > DEPTH_CNT)
            return DEPTH_CNT;
        else
            return fbpa_pkg::CNT_W'(n);
    endfunction

    // config registers
    logic [31:0] base_reg;
    logic [8:0]  chunks_reg;
    logic [3:0]  lg_reg;

    // pool state
    logic [fbpa_pkg::CNT_W-1:0] freed_top_reg, freed_top_next;
    logic [fbpa_pkg::CNT_W-1:0] fresh_left_reg, fresh_left_next;
    logic [fbpa_pkg::CNT_W-1:0] in_use_reg, in_use_next;

    // freed-chunk stack
    logic [fbpa_pkg::IDX_W-1:0] stack_mem [fbpa_pkg::POOL_DEPTH];
    logic [fbpa_pkg::IDX_W-1:0] rd_data_reg;
    logic [fbpa_pkg::IDX_W-1:0] top_m1;

    // captured request
    logic                       req_reg;
    logic                       size_ok_reg;
    logic                       in_range_reg;
    logic [fbpa_pkg::IDX_W-1:0] free_idx_reg;

    logic [fbpa_pkg::CNT_W-1:0] eff_chunks;
    logic [3:0]                 eff_lg;
    logic [20:0]                span;
    logic [31:0]                offset;
    logic                       in_range;
    logic                       size_ok;
    logic                       cfg_init;
    logic [fbpa_pkg::CNT_W-1:0] init_chunks;

    logic [2:0]                 stat;
    logic                       grant;
    logic [fbpa_pkg::IDX_W-1:0] grant_idx;
    logic                       push;

    assign eff_chunks = clamp_chunks(chunks_reg);
    assign eff_lg     = (lg_reg < fbpa_pkg::LG_MIN) ? fbpa_pkg::LG_MIN :
                        (lg_reg > fbpa_pkg::LG_MAX) ? fbpa_pkg::LG_MAX : lg_reg;

    // request-side checks, done in the capture cycle
    assign span     = 21'(eff_chunks) << eff_lg;
    assign offset   = release_addr - base_reg;
    assign in_range = (release_addr >= base_reg) && (offset < 32'(span));
    assign size_ok  = (request_size <= (13'd1 << eff_lg));
    assign top_m1   = fbpa_pkg::IDX_W'(freed_top_reg - fbpa_pkg::CNT_W'(1));

    // any listed register write re-initializes the pool
    assign cfg_init    = cfg.we && (cfg.idx == fbpa_pkg::REG_BASE ||
                                    cfg.idx == fbpa_pkg::REG_CHUNKS ||
                                    cfg.idx == fbpa_pkg::REG_LG);
    assign init_chunks = (cfg.idx == fbpa_pkg::REG_CHUNKS) ? clamp_chunks(cfg.wdata[8:0])
                                                           : eff_chunks;

    always_comb
    begin
        unique case (cfg.idx)
            fbpa_pkg::REG_BASE:   cfg_rdata = base_reg;
            fbpa_pkg::REG_CHUNKS: cfg_rdata = 32'(chunks_reg);
            fbpa_pkg::REG_LG:     cfg_rdata = 32'(lg_reg);
            default:              cfg_rdata = 32'd0;
        endcase
    end

    // commit-stage pool update
    always_comb
    begin
        freed_top_next  = freed_top_reg;
        fresh_left_next = fresh_left_reg;
        in_use_next     = in_use_reg;
        stat            = fbpa_pkg::ST_OK;
        grant           = 1'b0;
        grant_idx       = '0;
        push            = 1'b0;
        if (req_reg == fbpa_pkg::REQ_ALLOC)
        begin
            if (!size_ok_reg)
                stat = fbpa_pkg::ST_SIZE;
            else if (freed_top_reg != '0)
            begin
                freed_top_next = freed_top_reg - fbpa_pkg::CNT_W'(1);
                grant          = 1'b1;
                grant_idx      = rd_data_reg;
            end
            else if (fresh_left_reg != '0)
            begin
                fresh_left_next = fresh_left_reg - fbpa_pkg::CNT_W'(1);
                grant           = 1'b1;
                grant_idx       = fresh_left_next[fbpa_pkg::IDX_W-1:0];
            end
            else
                stat = fbpa_pkg::ST_EMPTY;
            if (grant)
                in_use_next = in_use_reg + fbpa_pkg::CNT_W'(1);
        end
        else
        begin
            if (!in_range_reg)
                stat = fbpa_pkg::ST_RANGE;
            else if (in_use_reg == '0)
                stat = fbpa_pkg::ST_IDLE;
            else
            begin
                if (freed_top_reg < DEPTH_CNT)
                begin
                    push           = 1'b1;
                    freed_top_next = freed_top_reg + fbpa_pkg::CNT_W'(1);
                end
                in_use_next = in_use_reg - fbpa_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= 32'd0;
            chunks_reg     <= 9'(fbpa_pkg::POOL_DEPTH);
            lg_reg         <= 4'd4;
            freed_top_reg  <= '0;
            fresh_left_reg <= DEPTH_CNT;
            in_use_reg     <= '0;
        end
        else if (cfg_init)
        begin
            if (cfg.idx == fbpa_pkg::REG_BASE)
                base_reg <= cfg.wdata;
            if (cfg.idx == fbpa_pkg::REG_CHUNKS)
                chunks_reg <= cfg.wdata[8:0];
            if (cfg.idx == fbpa_pkg::REG_LG)
                lg_reg <= cfg.wdata[3:0];
            freed_top_reg  <= '0;
            fresh_left_reg <= init_chunks;
            in_use_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            freed_top_reg  <= freed_top_next;
            fresh_left_reg <= fresh_left_next;
            in_use_reg     <= in_use_next;
        end
    end

    // stack memory: read on capture, write on commit
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rd_data_reg <= stack_mem[top_m1];
        if (cmd.commit && push && !cfg_init)
            stack_mem[freed_top_reg[fbpa_pkg::IDX_W-1:0]] <= free_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req_type;
            size_ok_reg  <= size_ok;
            in_range_reg <= in_range;
            free_idx_reg <= fbpa_pkg::IDX_W'(offset >> eff_lg);
        end
        if (cmd.commit)
        begin
            status      <= stat;
            chunk_addr  <= grant ? (base_reg + (32'(grant_idx) << eff_lg)) : 32'd0;
            used_chunks <= 9'(in_use_next);
            used_bytes  <= 21'(in_use_next) << eff_lg;
        end
    end

    // chunks are conserved: freed + fresh + in use never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (10'(freed_top_reg) + 10'(fresh_left_reg) + 10'(in_use_reg)) <= 10'(DEPTH_CNT))
        else $error("fbpa_dp: chunk accounting exceeds pool depth");

    // reported count tracks the live counter after a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !cfg_init) |=> (used_chunks == 9'(in_use_reg)))
        else $error("fbpa_dp: used_chunks does not match in-use count");

    // stack top moves by at most one per request
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_init |=> (freed_top_reg == $past(freed_top_reg) ||
                       freed_top_reg == $past(freed_top_reg) + fbpa_pkg::CNT_W'(1) ||
                       freed_top_reg == $past(freed_top_reg) - fbpa_pkg::CNT_W'(1)))
        else $error("fbpa_dp: freed stack top jumped");

endmodule

### hw/rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator. Hands out chunks of 2^chunk_size_log2 bytes
// from a pool of pool_chunks chunks starting at base_address. An allocate
// (req_type 0) returns the most recently freed chunk first, then never-used
// chunks from the highest index down; a free (req_type 1) range-checks the
// address (offset bits inside a chunk ignored) and pushes the chunk on the
// freed stack. Double frees are not detected. Every request gives exactly one
// result with status, chunk_addr and the used chunk/byte counts after it.
// A request is first captured, which also reads the top of the freed stack (a
// synchronous 256 x 8 memory), then committed, which updates the pool and loads
// the result register; the commit waits for as long as a prior result still
// waits on out_ready. A new request is taken while a prior result still waits
// on out_ready. No clearing pass after reset: stack entries are only used
// from below the top, so their contents never need initialization. Any write
// to a config register re-initializes the pool; write config only when idle.
module fixed_block_pool_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,

    // APB config port, pready tied high
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [12:0]                  request_size,
    input  logic [31:0]                  release_addr,

    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   status,
    output logic [31:0]                  chunk_addr,
    output logic [8:0]                   used_chunks,
    output logic [20:0]                  used_bytes
);

    fbpa_pkg::fbpa_cmd_t cmd;
    fbpa_pkg::fbpa_cfg_t cfg;

    // register write lands in the access phase; word index from paddr
    assign pready    = 1'b1;
    assign cfg.we    = psel && penable && pwrite;
    assign cfg.idx   = paddr[fbpa_pkg::PADDR_W-1:2];
    assign cfg.wdata = pwdata;

    fbpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    fbpa_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cfg_rdata    (prdata),
        .cmd          (cmd),
        .req_type     (req_type),
        .request_size (request_size),
        .release_addr (release_addr),
        .status       (status),
        .chunk_addr   (chunk_addr),
        .used_chunks  (used_chunks),
        .used_bytes   (used_bytes)
    );

endmodule
